### rtl/core/bpu_pkg.sv
// Shared types, register codes and constants for the bitmap pixel unpacker.
// No dependencies; every other file of the block imports this package.
package bpu_pkg;

    localparam int MAX_WIDTH               = 4096;
    localparam int PALETTE_ENTRIES_DEFAULT = 256;

    localparam int DIM_W       = 13;  // width, height, column and row counters
    localparam int ROW_BYTES_W = 14;  // byte position inside a padded row
    localparam int COUNT_W     = 4;   // pixels per byte, 0..8
    localparam int MAX_RUN     = 8;   // pixels in one 1bpp byte
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_MODE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_PRESENT = 2'd3;

    // Source pixel formats; the two unused codes behave as 24bpp
    localparam logic [2:0] MODE_1BPP  = 3'd0;
    localparam logic [2:0] MODE_4BPP  = 3'd1;
    localparam logic [2:0] MODE_8BPP  = 3'd2;
    localparam logic [2:0] MODE_16BPP = 3'd3;
    localparam logic [2:0] MODE_24BPP = 3'd4;
    localparam logic [2:0] MODE_32BPP = 3'd5;

    // Input item commands
    localparam logic CMD_PIXEL   = 1'b0;
    localparam logic CMD_PALETTE = 1'b1;

    typedef enum logic [1:0] {
        KIND_MONO,
        KIND_PAL4,
        KIND_PAL8,
        KIND_DIRECT
    } pix_kind_t;

    typedef struct packed {
        logic [2:0]       depth_mode;
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
        logic             palette_present;
    } cfg_t;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
        logic [7:0] palette_index;
        logic [7:0] palette_blue;
        logic [7:0] palette_green;
        logic [7:0] palette_red;
    } byte_item_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       run_last;
        logic       row_end;
        logic       image_end;
    } pixel_item_t;

    // Run descriptor for the pixel stage: everything one byte needs to emit its run
    typedef struct packed {
        pix_kind_t          kind;
        logic [COUNT_W-1:0] count;
        logic               ends_row;
        logic               last_row;
        logic               pal_present;
        logic [7:0]         mono_bits;
        logic               oor0;
        logic               oor1;
        logic [23:0]        color;
    } desc_t;

    // floor(c * 255 / 31) for a 5-bit component
    function automatic logic [7:0] expand5(input logic [4:0] c);
        logic [7:0] v;
        case (c)
            5'd0:  v = 8'd0;
            5'd1:  v = 8'd8;
            5'd2:  v = 8'd16;
            5'd3:  v = 8'd24;
            5'd4:  v = 8'd32;
            5'd5:  v = 8'd41;
            5'd6:  v = 8'd49;
            5'd7:  v = 8'd57;
            5'd8:  v = 8'd65;
            5'd9:  v = 8'd74;
            5'd10: v = 8'd82;
            5'd11: v = 8'd90;
            5'd12: v = 8'd98;
            5'd13: v = 8'd106;
            5'd14: v = 8'd115;
            5'd15: v = 8'd123;
            5'd16: v = 8'd131;
            5'd17: v = 8'd139;
            5'd18: v = 8'd148;
            5'd19: v = 8'd156;
            5'd20: v = 8'd164;
            5'd21: v = 8'd172;
            5'd22: v = 8'd180;
            5'd23: v = 8'd189;
            5'd24: v = 8'd197;
            5'd25: v = 8'd205;
            5'd26: v = 8'd213;
            5'd27: v = 8'd222;
            5'd28: v = 8'd230;
            5'd29: v = 8'd238;
            5'd30: v = 8'd246;
            default: v = 8'd255;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/bmp_pixel_unpacker_unit.sv
// Top level of the bitmap pixel unpacker.
// Depends on bpu_pkg, bpu_cfg_regs, bpu_frame_track, bpu_palette_ram, bpu_pixel_emit.
//
// Turns the pixel-data area of an uncompressed bitmap, one byte per transfer,
// into 24-bit blue/green/red pixels, one pixel per output transfer. Formats:
// 1, 4 and 8 bpp through the palette (1 bpp gives black/white when
// palette_present is 0), 16 bpp 5-5-5 expanded to 8 bits per component,
// 24 and 32 bpp copied (the fourth byte of a 32-bit pixel is dropped). Rows
// are padded to 4 bytes; padding bytes and pixels past the row width produce
// nothing. Palette entries are loaded by input transfers with command set; they
// produce no pixel. Reading a palette entry that was never written returns
// undefined color. A byte's run is registered in the pixel stage and each pixel
// again in the output register. The input side takes one byte per cycle while
// the output is not stalled, as long as each byte yields at most one pixel; a
// byte that yields more (up to 8 at 1 bpp, 2 at 4 bpp) holds the pixel stage,
// with byte_ready low, until the output register, which sends one pixel per
// cycle while not stalled, has taken its last pixel. Bytes with no pixel (padding,
// partial 16/24/32-bit pixels) still wait for byte_ready. Configuration may only
// be written while no pixels are pending; writes take effect on the next byte.
module bmp_pixel_unpacker_unit
    import bpu_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // byte channel
    input  logic                   byte_valid,
    output logic                   byte_ready,
    input  byte_item_t             byte_item,
    // pixel channel
    output logic                   pixel_valid,
    input  logic                   pixel_ready,
    output pixel_item_t            pixel_item
);

    cfg_t        cfg;
    desc_t       desc;
    logic [7:0]  rd_index0, rd_index1;
    logic [23:0] rd_color0, rd_color1;
    logic        slot_free;
    logic        byte_xfer;
    logic        pix_take;
    logic        pal_write;
    logic        desc_load;

    // A byte transfer completes whenever the pixel stage is empty or is
    // sending its final pixel this cycle.
    assign byte_ready = slot_free;
    assign byte_xfer  = byte_valid && byte_ready;
    assign pix_take   = byte_xfer && (byte_item.command == CMD_PIXEL);
    assign pal_write  = byte_xfer && (byte_item.command == CMD_PALETTE);

    // Bytes with no pixel only advance the counters; the pixel stage and the
    // palette read registers are left alone.
    assign desc_load = pix_take && (desc.count != '0);

    bpu_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bpu_frame_track #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_frame_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pix_take  (pix_take),
        .data_byte (byte_item.data_byte),
        .desc      (desc),
        .rd_index0 (rd_index0),
        .rd_index1 (rd_index1)
    );

    // Palette is read at byte transfer time, so later palette writes never
    // disturb a run already in the pixel stage.
    bpu_palette_ram #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_palette_ram (
        .clk       (clk),
        .wr_en     (pal_write),
        .wr_index  (byte_item.palette_index),
        .wr_color  ({byte_item.palette_red, byte_item.palette_green,
                     byte_item.palette_blue}),
        .rd_en     (desc_load),
        .rd_index0 (rd_index0),
        .rd_index1 (rd_index1),
        .rd_color0 (rd_color0),
        .rd_color1 (rd_color1)
    );

    bpu_pixel_emit u_pixel_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .desc_load   (desc_load),
        .desc        (desc),
        .rd_color0   (rd_color0),
        .rd_color1   (rd_color1),
        .slot_free   (slot_free),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel_item  (pixel_item)
    );

endmodule

### rtl/core/bpu_cfg_regs.sv
// Configuration register file of the bitmap pixel unpacker.
// Depends on bpu_pkg for register indexes and the cfg_t layout.
module bpu_cfg_regs
    import bpu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DEPTH_MODE:      cfg_next.depth_mode      = cfg_data[2:0];
                REG_IMAGE_WIDTH:     cfg_next.image_width     = cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT:    cfg_next.image_height    = cfg_data[DIM_W-1:0];
                REG_PALETTE_PRESENT: cfg_next.palette_present = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depth_mode      <= MODE_24BPP;
            cfg_reg.image_width     <= DIM_W'(1);
            cfg_reg.image_height    <= DIM_W'(1);
            cfg_reg.palette_present <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/bpu_palette_ram.sv
// Palette memory: one write port, two registered read ports.
// Depends on bpu_pkg for the default of PALETTE_ENTRIES.
module bpu_palette_ram
    import bpu_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT
)
(
    input  logic        clk,
    input  logic        wr_en,
    input  logic [7:0]  wr_index,
    input  logic [23:0] wr_color,
    input  logic        rd_en,
    input  logic [7:0]  rd_index0,
    input  logic [7:0]  rd_index1,
    output logic [23:0] rd_color0,
    output logic [23:0] rd_color1
);

    localparam int ADDR_W = $clog2(PALETTE_ENTRIES);

    logic [23:0] palette_mem [PALETTE_ENTRIES];
    logic [23:0] rd0_reg;
    logic [23:0] rd1_reg;
    logic        wr_in_range;

    // entries past the table are dropped on write
    assign wr_in_range = int'(wr_index) < PALETTE_ENTRIES;

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_in_range)
        begin
            palette_mem[wr_index[ADDR_W-1:0]] <= wr_color;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd0_reg <= palette_mem[rd_index0[ADDR_W-1:0]];
            rd1_reg <= palette_mem[rd_index1[ADDR_W-1:0]];
        end
    end

    assign rd_color0 = rd0_reg;
    assign rd_color1 = rd1_reg;

endmodule

### rtl/core/bpu_frame_track.sv
// Row/column/byte tracking and per-byte decode into a pixel run descriptor.
// Depends on bpu_pkg for cfg_t, desc_t, mode codes and expand5().
module bpu_frame_track
    import bpu_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       pix_take,
    input  logic [7:0] data_byte,
    output desc_t      desc,
    output logic [7:0] rd_index0,
    output logic [7:0] rd_index1
);

    localparam int ROW_BITS_W = DIM_W + 5;        // width times 32 bits
    localparam int PITCH_W    = ROW_BITS_W - 3;   // padded row length in bytes

    logic [ROW_BYTES_W-1:0] row_bytes_reg, row_bytes_next;
    logic [DIM_W-1:0]       column_reg, column_next;
    logic [DIM_W-1:0]       row_reg, row_next;
    logic [23:0]            partial_reg, partial_next;
    logic [1:0]             bip_reg, bip_next;

    logic [DIM_W-1:0]      eff_width, eff_height;
    logic [ROW_BITS_W-1:0] w_ext, row_bits, bits_rounded;
    logic [PITCH_W-1:0]    pitch, row_bytes_inc;
    logic                  row_done;
    logic                  col_ok;
    logic [DIM_W-1:0]      remaining;
    pix_kind_t             kind;
    logic [COUNT_W-1:0]    cap, count;
    logic [2:0]            nbytes;
    logic                  complete;
    logic [23:0]           partial_upd, color;
    logic                  last_row;

    always_comb
    begin
        if (cfg.image_width == '0)
            eff_width = DIM_W'(1);
        else if (cfg.image_width > DIM_W'(MAX_WIDTH))
            eff_width = DIM_W'(MAX_WIDTH);
        else
            eff_width = cfg.image_width;
        eff_height = (cfg.image_height == '0) ? DIM_W'(1) : cfg.image_height;
    end

    // padded pitch: ceil(width * bpp / 32) words of 4 bytes
    assign w_ext = ROW_BITS_W'(eff_width);

    always_comb
    begin
        unique case (cfg.depth_mode)
            MODE_1BPP:  row_bits = w_ext;
            MODE_4BPP:  row_bits = w_ext << 2;
            MODE_8BPP:  row_bits = w_ext << 3;
            MODE_16BPP: row_bits = w_ext << 4;
            MODE_32BPP: row_bits = w_ext << 5;
            default:    row_bits = (w_ext << 4) + (w_ext << 3);
        endcase
    end

    assign bits_rounded  = row_bits + ROW_BITS_W'(31);
    assign pitch         = {bits_rounded[ROW_BITS_W-1:5], 2'b00};
    assign row_bytes_inc = {1'b0, row_bytes_reg} + PITCH_W'(1);
    assign row_done      = row_bytes_inc >= pitch;

    assign col_ok    = column_reg < eff_width;
    assign remaining = eff_width - column_reg;
    assign last_row  = ({1'b0, row_reg} + (DIM_W + 1)'(1)) >= {1'b0, eff_height};

    // multi-byte formats
    always_comb
    begin
        unique case (cfg.depth_mode)
            MODE_16BPP: nbytes = 3'd2;
            MODE_32BPP: nbytes = 3'd4;
            default:    nbytes = 3'd3;
        endcase
    end

    assign complete = ({1'b0, bip_reg} + 3'd1) >= nbytes;

    always_comb
    begin
        partial_upd = partial_reg;
        case (bip_reg)
            2'd0:    partial_upd[7:0]   = data_byte;
            2'd1:    partial_upd[15:8]  = data_byte;
            2'd2:    partial_upd[23:16] = data_byte;
            default: ;  // fourth byte of a 32-bit pixel is dropped
        endcase
        if (nbytes == 3'd2)
            color = {expand5(partial_upd[14:10]), expand5(partial_upd[9:5]),
                     expand5(partial_upd[4:0])};
        else
            color = partial_upd;
    end

    always_comb
    begin
        unique case (cfg.depth_mode)
            MODE_1BPP:
            begin
                kind = KIND_MONO;
                cap  = COUNT_W'(MAX_RUN);
            end
            MODE_4BPP:
            begin
                kind = KIND_PAL4;
                cap  = COUNT_W'(2);
            end
            MODE_8BPP:
            begin
                kind = KIND_PAL8;
                cap  = COUNT_W'(1);
            end
            default:
            begin
                kind = KIND_DIRECT;
                cap  = complete ? COUNT_W'(1) : '0;
            end
        endcase
    end

    // pixels past the row width are not emitted
    always_comb
    begin
        if (!col_ok)
            count = '0;
        else if (remaining < DIM_W'(cap))
            count = remaining[COUNT_W-1:0];
        else
            count = cap;
    end

    // palette addresses; 1bpp always looks at entries 0 and 1
    always_comb
    begin
        unique case (kind) inside
            KIND_MONO:
            begin
                rd_index0 = 8'd0;
                rd_index1 = 8'd1;
            end
            KIND_PAL4:
            begin
                rd_index0 = {4'd0, data_byte[7:4]};
                rd_index1 = {4'd0, data_byte[3:0]};
            end
            KIND_PAL8, KIND_DIRECT:
            begin
                rd_index0 = data_byte;
                rd_index1 = data_byte;
            end
        endcase
    end

    always_comb
    begin
        desc.kind        = kind;
        desc.count       = count;
        desc.ends_row    = col_ok && (DIM_W'(cap) >= remaining);
        desc.last_row    = last_row;
        desc.pal_present = cfg.palette_present;
        desc.mono_bits   = data_byte;
        desc.oor0        = int'(rd_index0) >= PALETTE_ENTRIES;
        desc.oor1        = int'(rd_index1) >= PALETTE_ENTRIES;
        desc.color       = color;
    end

    always_comb
    begin
        row_bytes_next = row_bytes_reg;
        column_next    = column_reg;
        row_next       = row_reg;
        partial_next   = partial_reg;
        bip_next       = bip_reg;
        if (pix_take)
        begin
            if (row_done)
            begin
                row_bytes_next = '0;
                column_next    = '0;
                partial_next   = '0;
                bip_next       = '0;
                row_next       = last_row ? '0 : row_reg + DIM_W'(1);
            end
            else
            begin
                row_bytes_next = row_bytes_inc[ROW_BYTES_W-1:0];
                column_next    = column_reg + DIM_W'(count);
                if (kind == KIND_DIRECT)
                begin
                    if (complete)
                    begin
                        partial_next = '0;
                        bip_next     = '0;
                    end
                    else
                    begin
                        partial_next = partial_upd;
                        bip_next     = bip_reg + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg <= '0;
            column_reg    <= '0;
            row_reg       <= '0;
            partial_reg   <= '0;
            bip_reg       <= '0;
        end
        else
        begin
            row_bytes_reg <= row_bytes_next;
            column_reg    <= column_next;
            row_reg       <= row_next;
            partial_reg   <= partial_next;
            bip_reg       <= bip_next;
        end
    end

endmodule

### rtl/core/bpu_pixel_emit.sv
// Pixel stage: holds one byte's run and sends its pixels, one per cycle unless
// stalled, through the output register. Uses desc_t/pixel_item_t of bpu_pkg.
module bpu_pixel_emit
    import bpu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        desc_load,
    input  desc_t       desc,
    input  logic [23:0] rd_color0,
    input  logic [23:0] rd_color1,
    output logic        slot_free,
    output logic        pixel_valid,
    input  logic        pixel_ready,
    output pixel_item_t pixel_item
);

    desc_t       desc_reg;
    logic        run_valid_reg, run_valid_next;
    logic [2:0]  idx_reg, idx_next;
    pixel_item_t out_reg;
    logic        out_valid_reg, out_valid_next;

    logic        out_load;
    logic        run_fire;
    logic        run_last;
    logic        bit_sel;
    logic [23:0] color;
    pixel_item_t pixel;

    assign out_load  = !out_valid_reg || pixel_ready;
    assign run_fire  = run_valid_reg && out_load;
    assign run_last  = ({1'b0, idx_reg} + COUNT_W'(1)) == desc_reg.count;
    assign slot_free = !run_valid_reg || (run_fire && run_last);

    // leftmost pixel sits in the MSB
    assign bit_sel = desc_reg.mono_bits[3'd7 - idx_reg];

    always_comb
    begin
        unique case (desc_reg.kind)
            KIND_MONO:
            begin
                if (desc_reg.pal_present)
                    color = bit_sel ? rd_color1 : rd_color0;
                else
                    color = bit_sel ? 24'hFF_FFFF : 24'h00_0000;
            end
            KIND_PAL4:
            begin
                if (idx_reg == '0)
                    color = desc_reg.oor0 ? 24'h00_0000 : rd_color0;
                else
                    color = desc_reg.oor1 ? 24'h00_0000 : rd_color1;
            end
            KIND_PAL8:
                color = desc_reg.oor0 ? 24'h00_0000 : rd_color0;
            KIND_DIRECT:
                color = desc_reg.color;
        endcase
    end

    always_comb
    begin
        pixel.blue      = color[7:0];
        pixel.green     = color[15:8];
        pixel.red       = color[23:16];
        pixel.run_last  = run_last;
        pixel.row_end   = run_last && desc_reg.ends_row;
        pixel.image_end = run_last && desc_reg.ends_row && desc_reg.last_row;
    end

    always_comb
    begin
        run_valid_next = run_valid_reg;
        idx_next       = idx_reg;
        if (desc_load)
        begin
            run_valid_next = 1'b1;
            idx_next       = '0;
        end
        else if (run_fire)
        begin
            if (run_last)
                run_valid_next = 1'b0;
            else
                idx_next = idx_reg + 3'd1;
        end
        out_valid_next = out_load ? run_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            run_valid_reg <= run_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc_load)
            desc_reg <= desc;
        if (run_fire)
            out_reg <= pixel;
    end

    assign pixel_valid = out_valid_reg;
    assign pixel_item  = out_reg;

    a_run_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid_reg |-> (desc_reg.count != '0))
        else $error("pixel stage holds a run with no pixels");

    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid_reg |-> ({1'b0, idx_reg} < desc_reg.count))
        else $error("pixel index ran past the run");

    a_direct_single: assert property (@(posedge clk) disable iff (!rst_n)
        (run_valid_reg && desc_reg.kind == KIND_DIRECT) |-> (desc_reg.count == COUNT_W'(1)))
        else $error("multi-byte format produced more than one pixel");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        desc_load |-> slot_free)
        else $error("new run loaded over a run still in progress");

endmodule

### dv/tb.sv
// Self-checking testbench for bmp_pixel_unpacker_unit: directed table, then random images.
// Depends on bpu_pkg and the RTL of the unpacker; a built-in pixel predictor checks every output.
module tb
    import bpu_pkg::*;
();

    // Depth codes with no name in the package; the block treats both as 24bpp
    localparam logic [2:0] MODE_ALIAS6 = 3'd6;
    localparam logic [2:0] MODE_ALIAS7 = 3'd7;

    // Receiver stall styles
    localparam int RX_OPEN   = 0;
    localparam int RX_RANDOM = 1;
    localparam int RX_CHOKED = 2;

    localparam int DRAIN_CYCLES  = 4;    // slack after the last pixel before a register write
    localparam int END_CYCLES    = 16;
    localparam int RANDOM_ITEMS  = 190;
    localparam int MAX_PHASE_LEN = 96;

    // One row of the directed table: a register write or an input transfer,
    // optionally with the single pixel it must produce typed in by hand
    typedef struct packed {
        logic                   is_reg;
        logic [CFG_INDEX_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        byte_item_t             item;
        logic                   typed;
        pixel_item_t            want;
    } step_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   byte_valid = 1'b0;
    logic                   byte_ready;
    byte_item_t             byte_item = '0;
    logic                   pixel_valid;
    logic                   pixel_ready = 1'b0;
    pixel_item_t            pixel_item;

    bmp_pixel_unpacker_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .byte_item   (byte_item),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel_item  (pixel_item)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Pixel predictor: register copy plus the decode state of the block
    // ------------------------------------------------------------------
    logic [2:0]            depth = MODE_24BPP;
    logic [DIM_W-1:0]      img_w = DIM_W'(1);
    logic [DIM_W-1:0]      img_h = DIM_W'(1);
    logic                  pal_on = 1'b0;
    logic [23:0]           pal_mem [0:255];
    int                    row_bytes = 0;   // bytes taken in the current padded row
    int                    col = 0;         // pixels given in the current row
    int                    row = 0;
    logic [23:0]           pix_acc = '0;    // bytes of a 16/24/32-bit pixel so far
    int                    acc_bytes = 0;

    pixel_item_t           run_buf [0:MAX_RUN-1];
    int                    run_len;
    pixel_item_t           expected_pixels [$];
    int                    errors = 0;

    function automatic int eff_w();
        if (img_w == 0)
            return 1;
        if (img_w > MAX_WIDTH)
            return MAX_WIDTH;
        return int'(img_w);
    endfunction

    function automatic int eff_h();
        return (img_h == 0) ? 1 : int'(img_h);
    endfunction

    function automatic int depth_bits();
        case (depth)
            MODE_1BPP:  return 1;
            MODE_4BPP:  return 4;
            MODE_8BPP:  return 8;
            MODE_16BPP: return 16;
            MODE_32BPP: return 32;
            default:    return 24;
        endcase
    endfunction

    // Row pitch in bytes, padded to 32 bits
    function automatic int row_pitch();
        return ((eff_w() * depth_bits() + 31) / 32) * 4;
    endfunction

    // floor(c * 255 / 31)
    function automatic logic [7:0] scale5(input logic [4:0] c);
        int t;
        t = (int'(c) * 255) / 31;
        return t[7:0];
    endfunction

    // Pixels past the row width are dropped
    task automatic add_pixel(input logic [23:0] color);
        int w;
        w = eff_w();
        if (col < w && run_len < MAX_RUN)
        begin
            run_buf[run_len]           = '0;
            run_buf[run_len].blue      = color[7:0];
            run_buf[run_len].green     = color[15:8];
            run_buf[run_len].red       = color[23:16];
            run_buf[run_len].row_end   = (col + 1 == w);
            run_buf[run_len].image_end = (col + 1 == w) && (row + 1 >= eff_h());
            col++;
            run_len++;
        end
    endtask

    // Advance the predictor by one accepted transfer; fills run_buf/run_len
    task automatic decode_byte(input byte_item_t it);
        int          k;
        int          nbytes;
        logic [23:0] c;
        logic [15:0] v;
        run_len = 0;
        if (it.command == CMD_PALETTE)
        begin
            pal_mem[it.palette_index] = {it.palette_red, it.palette_green, it.palette_blue};
            return;
        end
        case (depth_bits())
            1:
            begin
                // leftmost pixel sits in the MSB
                for (k = 7; k >= 0; k--)
                begin
                    if (pal_on)
                        c = pal_mem[it.data_byte[k]];
                    else
                        c = it.data_byte[k] ? 24'hFFFFFF : 24'h000000;
                    add_pixel(c);
                end
            end
            4:
            begin
                add_pixel(pal_mem[it.data_byte[7:4]]);
                add_pixel(pal_mem[it.data_byte[3:0]]);
            end
            8:
                add_pixel(pal_mem[it.data_byte]);
            default:
            begin
                nbytes = depth_bits() / 8;
                if (acc_bytes < 3)
                    pix_acc[8*acc_bytes +: 8] = it.data_byte;
                // a depth change mid-pixel completes on the low bytes already held
                if (acc_bytes + 1 >= nbytes)
                begin
                    if (nbytes == 2)
                    begin
                        v = pix_acc[15:0];
                        c = {scale5(v[14:10]), scale5(v[9:5]), scale5(v[4:0])};
                    end
                    else
                        c = pix_acc;
                    add_pixel(c);
                    acc_bytes = 0;
                    pix_acc   = '0;
                end
                else
                    acc_bytes = (acc_bytes + 1) & 3;
            end
        endcase
        if (run_len > 0)
            run_buf[run_len-1].run_last = 1'b1;

        // ">=" so that a pitch shrunk mid-row ends the row on the next byte
        row_bytes++;
        if (row_bytes >= row_pitch())
        begin
            row_bytes = 0;
            col       = 0;
            acc_bytes = 0;
            pix_acc   = '0;
            row++;
            if (row >= eff_h())
                row = 0;
        end
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    int burst_left = 0;

    // Sender works in bursts; a gap of zero keeps valid up across the boundary
    task automatic push_byte(input byte_item_t it, input logic typed, input pixel_item_t want);
        int gap;
        int i;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                byte_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        byte_valid <= 1'b1;
        byte_item  <= it;
        do
            @(posedge clk);
        while (byte_ready !== 1'b1);
        // transfer happened at this edge
        decode_byte(it);
        if (typed)
            expected_pixels.push_back(want);
        else
            for (i = 0; i < run_len; i++)
                expected_pixels.push_back(run_buf[i]);
    endtask

    // Drop valid, let every expected pixel out, then give the pipe DRAIN_CYCLES of slack
    task automatic settle();
        byte_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_DEPTH_MODE:      depth  = val[2:0];
            REG_IMAGE_WIDTH:     img_w  = val;
            REG_IMAGE_HEIGHT:    img_h  = val;
            REG_PALETTE_PRESENT: pal_on = val[0];
            default: ;
        endcase
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver: stall style changes every so often; RX_OPEN gives stall-free stretches
    int rx_tick  = 0;
    int rx_hold  = 0;
    int rx_style = RX_OPEN;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pixel_ready <= 1'b0;
        else
        begin
            rx_tick++;
            if (rx_tick % 150 == 0)
                rx_style = $urandom_range(RX_OPEN, RX_CHOKED);
            case (rx_style)
                RX_OPEN:   pixel_ready <= 1'b1;
                RX_RANDOM: pixel_ready <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    if (rx_hold == 0)
                    begin
                        pixel_ready <= 1'b1;
                        rx_hold = $urandom_range(0, 7);
                    end
                    else
                    begin
                        pixel_ready <= 1'b0;
                        rx_hold--;
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Output checker
    // ------------------------------------------------------------------
    pixel_item_t oldest;

    task automatic check_field(input string name, input logic [7:0] exp, input logic [7:0] act);
        if (act !== exp)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, exp, act);
            errors++;
        end
    endtask

    // Values read right after the edge are the ones the edge sampled
    always @(posedge clk)
    begin
        if (rst_n && pixel_valid === 1'b1 && pixel_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: no pixel expected, actual %h", $time, pixel_item);
                errors++;
            end
            else
            begin
                oldest = expected_pixels.pop_front();
                check_field("blue",      oldest.blue,      pixel_item.blue);
                check_field("green",     oldest.green,     pixel_item.green);
                check_field("red",       oldest.red,       pixel_item.red);
                check_field("run_last",  8'(oldest.run_last),  8'(pixel_item.run_last));
                check_field("row_end",   8'(oldest.row_end),   8'(pixel_item.row_end));
                check_field("image_end", 8'(oldest.image_end), 8'(pixel_item.image_end));
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------
    function automatic step_t reg_step(input logic [CFG_INDEX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] val);
        step_t s;
        s         = '0;
        s.is_reg  = 1'b1;
        s.reg_idx = idx;
        s.reg_val = val;
        return s;
    endfunction

    function automatic step_t data_step(input logic [7:0] b);
        step_t s;
        s                = '0;
        s.item.command   = CMD_PIXEL;
        s.item.data_byte = b;
        return s;
    endfunction

    // A byte that must give the single pixel of a one-pixel image
    function automatic step_t lone_pixel_step(input logic [7:0] b, input logic [7:0] blue,
                                              input logic [7:0] green, input logic [7:0] red);
        step_t s;
        s                = data_step(b);
        s.typed          = 1'b1;
        s.want.blue      = blue;
        s.want.green     = green;
        s.want.red       = red;
        s.want.run_last  = 1'b1;
        s.want.row_end   = 1'b1;
        s.want.image_end = 1'b1;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        step_t       script [$];
        byte_item_t  it;
        int          i;
        int          sent;
        int          n;
        int          rem;
        int          pitch;
        logic [12:0] w;
        logic [12:0] h;

        // Out of reset: 24bpp, 1x1, no palette. One 3-byte pixel plus one pad byte.
        script.push_back(data_step(8'h00));
        script.push_back(data_step(8'hFF));
        script.push_back(lone_pixel_step(8'h80, 8'h00, 8'hFF, 8'h80));
        script.push_back(data_step(8'h5A));
        // 16bpp 5-5-5: all ones, then only the ignored top bit
        script.push_back(reg_step(REG_DEPTH_MODE, CFG_DATA_W'(MODE_16BPP)));
        script.push_back(data_step(8'hFF));
        script.push_back(lone_pixel_step(8'h7F, 8'hFF, 8'hFF, 8'hFF));
        script.push_back(data_step(8'h00));
        script.push_back(data_step(8'h00));
        script.push_back(data_step(8'h00));
        script.push_back(lone_pixel_step(8'h80, 8'h00, 8'h00, 8'h00));
        // mid-row here: the register writes below change width and height under way
        script.push_back(data_step(8'hAA));
        // 1bpp black/white, width saturates, height zero means one row
        script.push_back(reg_step(REG_IMAGE_WIDTH, 13'h1FFF));
        script.push_back(reg_step(REG_IMAGE_HEIGHT, 13'd0));
        script.push_back(reg_step(REG_DEPTH_MODE, CFG_DATA_W'(MODE_1BPP)));
        script.push_back(data_step(8'hA5));
        script.push_back(data_step(8'h00));
        script.push_back(reg_step(REG_PALETTE_PRESENT, 13'd1));
        script.push_back(data_step(8'h5A));
        // 4bpp with width zero: second nibble lies beyond the row
        script.push_back(reg_step(REG_DEPTH_MODE, CFG_DATA_W'(MODE_4BPP)));
        script.push_back(reg_step(REG_IMAGE_WIDTH, 13'd0));
        script.push_back(data_step(8'h3C));
        script.push_back(data_step(8'hF0));
        script.push_back(reg_step(REG_DEPTH_MODE, CFG_DATA_W'(MODE_8BPP)));
        script.push_back(reg_step(REG_IMAGE_WIDTH, 13'd2));
        script.push_back(reg_step(REG_IMAGE_HEIGHT, 13'd2));
        script.push_back(data_step(8'h00));
        script.push_back(data_step(8'hFF));
        script.push_back(reg_step(REG_DEPTH_MODE, CFG_DATA_W'(MODE_ALIAS6)));
        script.push_back(data_step(8'h01));
        script.push_back(data_step(8'h02));
        script.push_back(data_step(8'h03));
        script.push_back(reg_step(REG_DEPTH_MODE, CFG_DATA_W'(MODE_32BPP)));
        script.push_back(reg_step(REG_IMAGE_HEIGHT, 13'd4096));
        script.push_back(data_step(8'h11));
        script.push_back(data_step(8'h22));
        script.push_back(data_step(8'h33));
        script.push_back(data_step(8'h44));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole palette first so no lookup ever hits an unwritten entry.
        // Entries 0 and 1 carry the color extremes.
        for (i = 0; i < 256; i++)
        begin
            it               = '0;
            it.command       = CMD_PALETTE;
            it.palette_index = i[7:0];
            it.data_byte     = 8'($urandom_range(0, 255));
            it.palette_blue  = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom_range(0, 255));
            it.palette_green = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom_range(0, 255));
            it.palette_red   = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom_range(0, 255));
            push_byte(it, 1'b0, '0);
        end

        foreach (script[i])
        begin
            if (script[i].is_reg)
            begin
                settle();
                write_reg(script[i].reg_idx, script[i].reg_val);
            end
            else
                push_byte(script[i].item, script[i].typed, script[i].want);
        end

        // Random phases: new settings while idle, then a run of bytes. Most runs
        // finish the current image (and maybe one more); the rest stop anywhere,
        // so the next settings land mid-row or mid-pixel.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            settle();
            if ($urandom_range(0, 1))
                write_reg(REG_DEPTH_MODE, 13'($urandom_range(0, 7)));
            if ($urandom_range(0, 1))
            begin
                case ($urandom_range(0, 9))
                    0:       w = 13'd0;
                    1:       w = 13'd4096;
                    2:       w = 13'h1FFF;
                    3:       w = 13'($urandom_range(13, 8191));
                    default: w = 13'($urandom_range(1, 12));
                endcase
                write_reg(REG_IMAGE_WIDTH, w);
            end
            if ($urandom_range(0, 1))
            begin
                case ($urandom_range(0, 9))
                    0:       h = 13'd0;
                    1:       h = 13'd4096;
                    2:       h = 13'h1FFF;
                    3:       h = 13'($urandom_range(5, 8191));
                    default: h = 13'($urandom_range(1, 4));
                endcase
                write_reg(REG_IMAGE_HEIGHT, h);
            end
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_PALETTE_PRESENT, 13'($urandom_range(0, 1)));

            if ($urandom_range(0, 3) != 0)
            begin
                pitch = row_pitch();
                rem = (row_bytes >= pitch) ? 1 : pitch - row_bytes;
                if (row < eff_h() - 1)
                    rem += pitch * (eff_h() - 1 - row);
                n = rem;
                if ($urandom_range(0, 1))
                    n += pitch * eff_h();
                if (n > MAX_PHASE_LEN)
                    n = MAX_PHASE_LEN;
            end
            else
                n = $urandom_range(1, 40);
            if (n > RANDOM_ITEMS - sent)
                n = RANDOM_ITEMS - sent;

            for (i = 0; i < n; i++)
            begin
                it.palette_index = 8'($urandom_range(0, 255));
                it.palette_blue  = 8'($urandom_range(0, 255));
                it.palette_green = 8'($urandom_range(0, 255));
                it.palette_red   = 8'($urandom_range(0, 255));
                case ($urandom_range(0, 15))
                    0:       it.data_byte = 8'h00;
                    1:       it.data_byte = 8'hFF;
                    default: it.data_byte = 8'($urandom_range(0, 255));
                endcase
                // an occasional palette rewrite inside the image
                it.command = ($urandom_range(0, 15) == 0) ? CMD_PALETTE : CMD_PIXEL;
                push_byte(it, 1'b0, '0);
                sent++;
            end
        end

        byte_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);
        if (errors == 0 && expected_pixels.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run
    initial
    begin
        #4800000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
